// ===== hdl/plt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the piecewise-linear transfer unit
// Command, status and register codes, the sequencer states, the reset
// contents of both point tables and the palette byte conversion.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int POS_W     = 16;
  localparam int VAL_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int REG_IDX_W = 1;
  localparam int CHAN_W    = 2;

  // Spans of this many LSB or fewer give a weight of zero.
  localparam int NARROW_SPAN = 6;

  localparam logic [CMD_W-1:0] CMD_WRITE_COLOR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_OPACITY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE        = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_SAMPLE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRITE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_COLOR_COUNT   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_OPACITY_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET   = 7'd4;
  localparam logic [COUNT_W-1:0] OPACITY_COUNT_RESET = 7'd5;

  // Channel slots of a stored entry. Opacity entries put alpha in the red slot.
  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_CHK_HI,
    S_RD_MID,
    S_CHK_MID,
    S_RD_L,
    S_RD_R,
    S_GOT_R,
    S_WEIGHT,
    S_DIV,
    S_MUL,
    S_ACC,
    S_FINISH
  } state_t;

  // Color entry layout: {position, red, green, blue}.
  function automatic logic [63:0] color_reset_entry(input logic [31:0] idx);
    logic [63:0] e;
    case (idx)
      32'd0:   e = {16'd0,     16'h0000, 16'h0000, 16'hFFFF};
      32'd1:   e = {16'd19661, 16'h0000, 16'hFFFF, 16'hFFFF};
      32'd2:   e = {16'd39322, 16'hFFFF, 16'hFFFF, 16'h0000};
      32'd3:   e = {16'hFFFF,  16'hFFFF, 16'h0000, 16'h0000};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Opacity entry layout: {position, alpha}.
  function automatic logic [31:0] opacity_reset_entry(input logic [31:0] idx);
    logic [31:0] e;
    case (idx)
      32'd0:   e = {16'd0,     16'd0};
      32'd1:   e = {16'd16384, 16'd16384};
      32'd2:   e = {16'd32768, 16'd32768};
      32'd3:   e = {16'd49152, 16'd49152};
      32'd4:   e = {16'hFFFF,  16'hFFFF};
      default: e = '0;
    endcase
    return e;
  endfunction

  // floor(v * 255 / 65535) equals floor(v / 257), which this shift form gives
  // exactly over the whole 16-bit range.
  function automatic logic [BYTE_W-1:0] palette_byte(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] t;
    t = v - (v >> 8);
    return t[15:8];
  endfunction

endpackage

// ===== hdl/piecewise_linear_transfer_function_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_function_unit: color and opacity transfer lookup
// Stores color and opacity control points and samples both tables at a query
// position by binary search and linear interpolation, with palette bytes.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                         Taken when
// -------   ---------------------------------------------   -----------------------
// request   start, busy, command, point_index, position,    start high, busy low
//           red_in, green_in, blue_in, alpha_in
// result    done, status, red_out, green_out, blue_out,     done high, one cycle
//           alpha_out, palette_red/green/blue
// config    cfg_we, cfg_index, cfg_data                     cfg_we high
//
// A write request or a bad request produces its result in the cycle after it is
// taken, and busy stays low, so such requests can follow one another each cycle.
// A sample request runs the color table and then the opacity table through one
// sequencer: per table it probes the ends, takes the binary-search steps,
// fetches the pair, forms the weight (with the bit-serial divider when a
// division is needed) and blends each channel on the shared multiplier; a
// final state loads the result. Busy stays high throughout, so the next
// request waits. The divider and the single read port of each table bound
// how long a sample takes.
// After reset a clearing pass writes the default tables with busy high;
// configuration writes are taken during it. The receiver cannot stall: every
// result is shown for exactly one cycle.
//
module piecewise_linear_transfer_function_unit #(
  parameter int MAX_POINTS    = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Requests
  input  logic                            start,
  output logic                            busy,
  input  logic [plt_pkg::CMD_W-1:0]       command,
  input  logic [plt_pkg::INDEX_W-1:0]     point_index,
  input  logic [plt_pkg::POS_W-1:0]       position,
  input  logic [plt_pkg::VAL_W-1:0]       red_in,
  input  logic [plt_pkg::VAL_W-1:0]       green_in,
  input  logic [plt_pkg::VAL_W-1:0]       blue_in,
  input  logic [plt_pkg::VAL_W-1:0]       alpha_in,
  // Results
  output logic                            done,
  output logic [plt_pkg::STATUS_W-1:0]    status,
  output logic [plt_pkg::VAL_W-1:0]       red_out,
  output logic [plt_pkg::VAL_W-1:0]       green_out,
  output logic [plt_pkg::VAL_W-1:0]       blue_out,
  output logic [plt_pkg::VAL_W-1:0]       alpha_out,
  output logic [plt_pkg::BYTE_W-1:0]      palette_red,
  output logic [plt_pkg::BYTE_W-1:0]      palette_green,
  output logic [plt_pkg::BYTE_W-1:0]      palette_blue,
  // Configuration
  input  logic                            cfg_we,
  input  logic [plt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [plt_pkg::COUNT_W-1:0]     cfg_data
);

  // Address width of the tables and a count width that can hold MAX_POINTS.
  localparam int IW     = $clog2(MAX_POINTS);
  localparam int CW     = IW + 1;
  localparam int DCW    = $clog2(FRACTION_BITS);
  localparam int PROD_W = FRACTION_BITS + 19;

  localparam logic [IW-1:0]          CLR_LAST = IW'(MAX_POINTS - 1);
  localparam logic [DCW-1:0]         DIV_LAST = DCW'(FRACTION_BITS - 1);
  localparam logic [FRACTION_BITS:0] W_ONE    = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [16:0]     SPAN_LIM = 17'(plt_pkg::NARROW_SPAN);

  plt_pkg::state_t state, state_next;

  // Configuration registers.
  logic [plt_pkg::COUNT_W-1:0] color_point_count;
  logic [plt_pkg::COUNT_W-1:0] opacity_point_count;

  // Tables and their registered read data.
  logic [63:0] color_mem   [MAX_POINTS];
  logic [31:0] opacity_mem [MAX_POINTS];
  logic [63:0] color_rd;
  logic [31:0] opacity_rd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] clr_addr;

  // Sequencer datapath registers.
  logic [15:0]              query;
  logic                     tbl;       // 0 while sampling color, 1 for opacity
  logic [IW-1:0]            lo, hi;
  logic [IW-1:0]            ridx;
  logic [63:0]              left, right;
  logic [FRACTION_BITS:0]   weight;
  logic [15:0]              rem, divisor;
  logic [FRACTION_BITS-1:0] quot;
  logic [DCW-1:0]           div_cnt;
  logic signed [PROD_W-1:0] prod;
  logic [plt_pkg::CHAN_W-1:0] ch;
  logic [15:0]              res_red, res_green, res_blue, res_alpha;

  // Combinational helpers.
  logic [CW-1:0] color_usable, opacity_usable, cur_count, cnt_m1;
  logic [63:0]   entry_sel;
  logic [15:0]   rd_pos;
  logic [IW:0]   lohi_sum, nlohi_sum;
  logic [IW-1:0] mid, nlo, nhi, nmid;
  logic          found;
  logic [CW-1:0] raw_idx, clamped_idx;
  logic          write_in_range, color_we, opacity_we;

  always_comb begin
    if (color_point_count < 7'd2) begin
      color_usable = CW'(2);
    end else if (32'(color_point_count) > 32'(MAX_POINTS)) begin
      color_usable = CW'(MAX_POINTS);
    end else begin
      color_usable = CW'(color_point_count);
    end
    if (opacity_point_count < 7'd2) begin
      opacity_usable = CW'(2);
    end else if (32'(opacity_point_count) > 32'(MAX_POINTS)) begin
      opacity_usable = CW'(MAX_POINTS);
    end else begin
      opacity_usable = CW'(opacity_point_count);
    end
  end

  assign cur_count = tbl ? opacity_usable : color_usable;
  assign cnt_m1    = cur_count - CW'(1);

  // Opacity entries are widened so that position and alpha sit where a color
  // entry keeps position and red.
  assign entry_sel = tbl ? {opacity_rd, 32'h0} : color_rd;
  assign rd_pos    = entry_sel[63:48];

  assign lohi_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid       = lohi_sum[IW:1];
  assign nlo       = (rd_pos <= query) ? mid : lo;
  assign nhi       = (rd_pos <= query) ? hi : mid;
  assign nlohi_sum = {1'b0, nlo} + {1'b0, nhi};
  assign nmid      = nlohi_sum[IW:1];

  always_comb begin
    if (raw_idx < CW'(1)) begin
      clamped_idx = CW'(1);
    end else if (raw_idx > cnt_m1) begin
      clamped_idx = cnt_m1;
    end else begin
      clamped_idx = raw_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Table writes: the clearing pass after reset, then write requests.
  // ---------------------------------------------------------------------------
  assign write_in_range = 32'(point_index) < 32'(MAX_POINTS);
  assign color_we   = (state == plt_pkg::S_IDLE) && start && write_in_range &&
                      (command == plt_pkg::CMD_WRITE_COLOR);
  assign opacity_we = (state == plt_pkg::S_IDLE) && start && write_in_range &&
                      (command == plt_pkg::CMD_WRITE_OPACITY);

  always_ff @(posedge clk) begin
    if (state == plt_pkg::S_CLEAR) begin
      color_mem[clr_addr]   <= plt_pkg::color_reset_entry(32'(clr_addr));
      opacity_mem[clr_addr] <= plt_pkg::opacity_reset_entry(32'(clr_addr));
    end else begin
      if (color_we) begin
        color_mem[IW'(point_index)] <= {position, red_in, green_in, blue_in};
      end
      if (opacity_we) begin
        opacity_mem[IW'(point_index)] <= {position, alpha_in};
      end
    end
    color_rd   <= color_mem[rd_addr];
    opacity_rd <= opacity_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      color_point_count   <= plt_pkg::COLOR_COUNT_RESET;
      opacity_point_count <= plt_pkg::OPACITY_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        plt_pkg::REG_COLOR_COUNT:   color_point_count   <= cfg_data;
        plt_pkg::REG_OPACITY_COUNT: opacity_point_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The search follows a fixed probe order: lowest point, highest
  // point, then midpoints. After the first midpoint the end checks are known
  // to fail, so later steps only read the new midpoint.
  // ---------------------------------------------------------------------------
  logic signed [16:0] span, num;
  logic [15:0]        un, ud;
  logic               zero_w, w_direct;

  assign span   = $signed({1'b0, right[63:48]}) - $signed({1'b0, left[63:48]});
  assign num    = $signed({1'b0, query}) - $signed({1'b0, left[63:48]});
  assign un     = num[16] ? 16'(-num) : num[15:0];
  assign ud     = span[16] ? 16'(-span) : span[15:0];
  // Narrow spans, a query on the left point and a query on the wrong side all
  // take the left value.
  assign zero_w = ((span >= -SPAN_LIM) && (span <= SPAN_LIM)) || (num == 17'sd0) ||
                  (num[16] != span[16]);
  // With the query at or past the right point the weight saturates to one.
  assign w_direct = zero_w || (un >= ud);

  logic                          last_ch;
  logic                          div_last;

  assign last_ch  = tbl ? (ch == plt_pkg::CH_RED) : (ch == plt_pkg::CH_BLUE);
  assign div_last = (div_cnt == DIV_LAST);

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    found      = 1'b0;
    raw_idx    = '0;
    case (state)
      plt_pkg::S_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = plt_pkg::S_IDLE;
      end
      plt_pkg::S_IDLE: begin
        if (start && (command == plt_pkg::CMD_SAMPLE)) state_next = plt_pkg::S_RD_LO;
      end
      plt_pkg::S_RD_LO: begin
        state_next = plt_pkg::S_RD_HI;
      end
      plt_pkg::S_RD_HI: begin
        rd_addr = hi;
        if (rd_pos > query) begin
          found      = 1'b1;
          raw_idx    = '0;
          state_next = plt_pkg::S_RD_L;
        end else begin
          state_next = plt_pkg::S_CHK_HI;
        end
      end
      plt_pkg::S_CHK_HI: begin
        if (rd_pos <= query) begin
          found      = 1'b1;
          raw_idx    = {1'b0, hi} + CW'(1);
          state_next = plt_pkg::S_RD_L;
        end else if ((mid == lo) || (mid == hi)) begin
          found      = 1'b1;
          raw_idx    = {1'b0, mid} + CW'(1);
          state_next = plt_pkg::S_RD_L;
        end else begin
          state_next = plt_pkg::S_RD_MID;
        end
      end
      plt_pkg::S_RD_MID: begin
        rd_addr    = mid;
        state_next = plt_pkg::S_CHK_MID;
      end
      plt_pkg::S_CHK_MID: begin
        if ((nmid == nlo) || (nmid == nhi)) begin
          found      = 1'b1;
          raw_idx    = {1'b0, nmid} + CW'(1);
          state_next = plt_pkg::S_RD_L;
        end else begin
          state_next = plt_pkg::S_RD_MID;
        end
      end
      plt_pkg::S_RD_L: begin
        rd_addr    = ridx - IW'(1);
        state_next = plt_pkg::S_RD_R;
      end
      plt_pkg::S_RD_R: begin
        rd_addr    = ridx;
        state_next = plt_pkg::S_GOT_R;
      end
      plt_pkg::S_GOT_R: begin
        state_next = plt_pkg::S_WEIGHT;
      end
      plt_pkg::S_WEIGHT: begin
        state_next = w_direct ? plt_pkg::S_MUL : plt_pkg::S_DIV;
      end
      plt_pkg::S_DIV: begin
        if (div_last) state_next = plt_pkg::S_MUL;
      end
      plt_pkg::S_MUL: begin
        state_next = plt_pkg::S_ACC;
      end
      plt_pkg::S_ACC: begin
        if (!last_ch) begin
          state_next = plt_pkg::S_MUL;
        end else if (tbl) begin
          state_next = plt_pkg::S_FINISH;
        end else begin
          state_next = plt_pkg::S_RD_LO;
        end
      end
      plt_pkg::S_FINISH: begin
        state_next = plt_pkg::S_IDLE;
      end
      default: state_next = plt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != plt_pkg::S_IDLE);

  // ---------------------------------------------------------------------------
  // Shared arithmetic: a restoring divider producing one weight bit per cycle
  // and one multiplier that blends a channel as l + floor((r - l) * w / one).
  // ---------------------------------------------------------------------------
  logic [16:0]              rem_shift;
  logic                     rem_ge;
  logic [FRACTION_BITS-1:0] quot_shift;
  logic [15:0]              left_val, right_val;
  logic signed [16:0]       chan_diff;
  logic signed [FRACTION_BITS+1:0] wsig;
  logic signed [PROD_W-1:0] blend_sum;
  logic [15:0]              blend_val;

  assign rem_shift  = {rem, 1'b0};
  assign rem_ge     = rem_shift >= {1'b0, divisor};
  assign quot_shift = {quot[FRACTION_BITS-2:0], rem_ge};

  always_comb begin
    case (ch)
      plt_pkg::CH_RED: begin
        left_val  = left[47:32];
        right_val = right[47:32];
      end
      plt_pkg::CH_GREEN: begin
        left_val  = left[31:16];
        right_val = right[31:16];
      end
      default: begin
        left_val  = left[15:0];
        right_val = right[15:0];
      end
    endcase
  end

  assign chan_diff = $signed({1'b0, right_val}) - $signed({1'b0, left_val});
  assign wsig      = $signed({1'b0, weight});
  assign blend_sum = (prod >>> FRACTION_BITS) + PROD_W'($signed({1'b0, left_val}));
  assign blend_val = blend_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      clr_addr <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        plt_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
        end
        plt_pkg::S_IDLE: begin
          if (start) begin
            query <= position;
            tbl   <= 1'b0;
            ch    <= plt_pkg::CH_RED;
            if (command != plt_pkg::CMD_SAMPLE) begin
              // Writes and bad requests answer at once with zero payload.
              done          <= 1'b1;
              status        <= (color_we || opacity_we) ? plt_pkg::STATUS_WRITE
                                                        : plt_pkg::STATUS_ERROR;
              red_out       <= '0;
              green_out     <= '0;
              blue_out      <= '0;
              alpha_out     <= '0;
              palette_red   <= '0;
              palette_green <= '0;
              palette_blue  <= '0;
            end
          end
        end
        plt_pkg::S_RD_LO: begin
          lo <= '0;
          hi <= IW'(cnt_m1);
        end
        plt_pkg::S_RD_HI, plt_pkg::S_CHK_HI: begin
          if (found) ridx <= IW'(clamped_idx);
        end
        plt_pkg::S_CHK_MID: begin
          lo <= nlo;
          hi <= nhi;
          if (found) ridx <= IW'(clamped_idx);
        end
        plt_pkg::S_RD_R: begin
          left <= entry_sel;
        end
        plt_pkg::S_GOT_R: begin
          right <= entry_sel;
        end
        plt_pkg::S_WEIGHT: begin
          if (zero_w) begin
            weight <= '0;
          end else if (un >= ud) begin
            weight <= W_ONE;
          end
          rem     <= un;
          divisor <= ud;
          quot    <= '0;
          div_cnt <= '0;
        end
        plt_pkg::S_DIV: begin
          rem     <= rem_ge ? 16'(rem_shift - {1'b0, divisor}) : rem_shift[15:0];
          quot    <= quot_shift;
          div_cnt <= div_cnt + DCW'(1);
          if (div_last) weight <= {1'b0, quot_shift};
        end
        plt_pkg::S_MUL: begin
          prod <= chan_diff * wsig;
        end
        plt_pkg::S_ACC: begin
          if (tbl) begin
            res_alpha <= blend_val;
          end else begin
            case (ch)
              plt_pkg::CH_RED:   res_red   <= blend_val;
              plt_pkg::CH_GREEN: res_green <= blend_val;
              default:           res_blue  <= blend_val;
            endcase
          end
          if (last_ch) begin
            ch  <= plt_pkg::CH_RED;
            tbl <= 1'b1;
          end else begin
            ch <= ch + plt_pkg::CHAN_W'(1);
          end
        end
        plt_pkg::S_FINISH: begin
          done          <= 1'b1;
          status        <= plt_pkg::STATUS_SAMPLE;
          red_out       <= res_red;
          green_out     <= res_green;
          blue_out      <= res_blue;
          alpha_out     <= res_alpha;
          palette_red   <= plt_pkg::palette_byte(res_red);
          palette_green <= plt_pkg::palette_byte(res_green);
          palette_blue  <= plt_pkg::palette_byte(res_blue);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/plt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_checker: port-level checks of the transfer function unit
// Watches the request, result and busy ports and flags results that appear
// without a request or that carry inconsistent payload.
// ----------------------------------------------------------------------------
module plt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [plt_pkg::STATUS_W-1:0]  status,
  input logic [plt_pkg::VAL_W-1:0]     red_out,
  input logic [plt_pkg::VAL_W-1:0]     green_out,
  input logic [plt_pkg::VAL_W-1:0]     blue_out,
  input logic [plt_pkg::VAL_W-1:0]     alpha_out,
  input logic [plt_pkg::BYTE_W-1:0]    palette_red,
  input logic [plt_pkg::BYTE_W-1:0]    palette_green,
  input logic [plt_pkg::BYTE_W-1:0]    palette_blue
);

  // A taken request either answers in the next cycle or keeps the unit busy.
  a_request_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request neither answered nor in progress");

  // A result only follows a taken request or work in progress.
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request");

  a_result_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_plain_result_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != plt_pkg::STATUS_SAMPLE)) |->
      ((red_out == '0) && (green_out == '0) && (blue_out == '0) &&
       (alpha_out == '0) && (palette_red == '0) && (palette_green == '0) &&
       (palette_blue == '0)))
    else $error("write or error result carries nonzero payload");

  // A palette byte is the value over 257, so it sits at or just below the
  // value's high byte.
  a_palette_tracks_value: assert property (@(posedge clk) disable iff (rst)
    (done && (status == plt_pkg::STATUS_SAMPLE)) |->
      ((palette_red <= red_out[15:8]) &&
       ({1'b0, palette_red} + 9'd1 >= {1'b0, red_out[15:8]}) &&
       (palette_blue <= blue_out[15:8]) &&
       ({1'b0, palette_blue} + 9'd1 >= {1'b0, blue_out[15:8]})))
    else $error("palette byte disagrees with color value");

endmodule

bind piecewise_linear_transfer_function_unit plt_checker u_plt_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the piecewise-linear transfer unit
// Drives write, sample and invalid requests through the start/busy port, sets
// the point-count registers across their legal and out-of-range values, and
// compares every result with a cycle-free model of both tables or a typed row.
// ----------------------------------------------------------------------------
module testbench;
  import plt_pkg::*;

  // The one command code the package leaves unnamed; the block must reject it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int FRACTION_BITS = 16;
  localparam int MAX_POINTS    = 64;
  localparam longint unsigned WEIGHT_ONE = 64'd1 << FRACTION_BITS;

  localparam int N_DIRECTED  = 21;
  localparam int N_SETTINGS  = 7;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   red;
    logic [VAL_W-1:0]   green;
    logic [VAL_W-1:0]   blue;
    logic [VAL_W-1:0]   alpha;
  } tf_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    red;
    logic [VAL_W-1:0]    green;
    logic [VAL_W-1:0]    blue;
    logic [VAL_W-1:0]    alpha;
    logic [BYTE_W-1:0]   pal_red;
    logic [BYTE_W-1:0]   pal_green;
    logic [BYTE_W-1:0]   pal_blue;
  } tf_result_t;

  // One line of the directed stimulus. When typed is set, the expected result
  // is the hand-written one instead of the model's.
  typedef struct packed {
    tf_request_t req;
    logic        typed;
    tf_result_t  want;
  } tf_row_t;

  localparam tf_result_t WRITE_ACK = '{status: STATUS_WRITE, default: '0};
  localparam tf_result_t ERROR_ACK = '{status: STATUS_ERROR, default: '0};

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0]     command = '0;
  logic [INDEX_W-1:0]   point_index = '0;
  logic [POS_W-1:0]     position = '0;
  logic [VAL_W-1:0]     red_in = '0;
  logic [VAL_W-1:0]     green_in = '0;
  logic [VAL_W-1:0]     blue_in = '0;
  logic [VAL_W-1:0]     alpha_in = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [VAL_W-1:0]     red_out;
  logic [VAL_W-1:0]     green_out;
  logic [VAL_W-1:0]     blue_out;
  logic [VAL_W-1:0]     alpha_out;
  logic [BYTE_W-1:0]    palette_red;
  logic [BYTE_W-1:0]    palette_green;
  logic [BYTE_W-1:0]    palette_blue;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]   cfg_data = '0;

  piecewise_linear_transfer_function_unit #(
    .MAX_POINTS   (MAX_POINTS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .point_index  (point_index),
    .position     (position),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .alpha_in     (alpha_in),
    .done         (done),
    .status       (status),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .palette_red  (palette_red),
    .palette_green(palette_green),
    .palette_blue (palette_blue),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net: a correct run finishes in well under a tenth of this time.
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the block's tables and count registers. It is updated at the
  // moment a request or register write is taken, so it always matches what the
  // block should hold when the next request arrives.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] color_pos   [MAX_POINTS];
  logic [VAL_W-1:0] color_red   [MAX_POINTS];
  logic [VAL_W-1:0] color_green [MAX_POINTS];
  logic [VAL_W-1:0] color_blue  [MAX_POINTS];
  logic [POS_W-1:0] opacity_pos [MAX_POINTS];
  logic [VAL_W-1:0] opacity_val [MAX_POINTS];
  logic [COUNT_W-1:0] color_count;
  logic [COUNT_W-1:0] opacity_count;

  tf_result_t awaited_results[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned n_samples;
  int unsigned n_writes;
  int unsigned n_bad;
  int unsigned burst_left;

  // Power-on contents: a blue-cyan-yellow-red color map and a linear ramp of
  // opacity; everything beyond those points reads as zero.
  task automatic load_default_tables();
    for (int i = 0; i < MAX_POINTS; i++) begin
      color_pos[i]   = '0;
      color_red[i]   = '0;
      color_green[i] = '0;
      color_blue[i]  = '0;
      opacity_pos[i] = '0;
      opacity_val[i] = '0;
    end
    color_blue[0]  = 16'hFFFF;
    color_pos[1]   = 16'd19661;
    color_green[1] = 16'hFFFF;
    color_blue[1]  = 16'hFFFF;
    color_pos[2]   = 16'd39322;
    color_red[2]   = 16'hFFFF;
    color_green[2] = 16'hFFFF;
    color_pos[3]   = 16'hFFFF;
    color_red[3]   = 16'hFFFF;
    for (int i = 1; i < 5; i++) begin
      opacity_pos[i] = (i == 4) ? 16'hFFFF : 16'(i * 16384);
      opacity_val[i] = opacity_pos[i];
    end
    color_count   = COLOR_COUNT_RESET;
    opacity_count = OPACITY_COUNT_RESET;
  endtask

  // Counts below two act as two, counts beyond the table act as the table size.
  function automatic int unsigned usable(logic [COUNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > MAX_POINTS) return MAX_POINTS;
    return c;
  endfunction

  function automatic logic [POS_W-1:0] pos_at(logic on_opacity, int unsigned i);
    return on_opacity ? opacity_pos[i] : color_pos[i];
  endfunction

  // First point whose position exceeds the query, following the block's fixed
  // probe order (ends first, then halving), clamped so a full pair exists.
  function automatic int unsigned right_index(logic on_opacity, int unsigned count,
                                              logic [POS_W-1:0] q);
    int unsigned lo, hi, mid, idx;
    lo = 0;
    hi = count - 1;
    while (1) begin
      mid = (lo + hi) / 2;
      if (pos_at(on_opacity, lo) > q) begin
        idx = lo;
        break;
      end
      if (pos_at(on_opacity, hi) <= q) begin
        idx = hi + 1;
        break;
      end
      if (mid == lo || mid == hi) begin
        idx = mid + 1;
        break;
      end
      if (pos_at(on_opacity, mid) <= q) lo = mid;
      else hi = mid;
    end
    if (idx < 1) idx = 1;
    if (idx > count - 1) idx = count - 1;
    return idx;
  endfunction

  // Weight of the right point, 0 .. 1.0 with FRACTION_BITS fraction bits.
  // Narrow spans and queries on the wrong side of the left point give zero.
  function automatic longint unsigned pair_weight(logic [POS_W-1:0] pl,
                                                  logic [POS_W-1:0] pr,
                                                  logic [POS_W-1:0] q);
    int span, num;
    longint unsigned w;
    span = int'({16'd0, pr}) - int'({16'd0, pl});
    num  = int'({16'd0, q}) - int'({16'd0, pl});
    if (span >= -NARROW_SPAN && span <= NARROW_SPAN) return 0;
    if (num == 0) return 0;
    if ((num > 0) != (span > 0)) return 0;
    if (num < 0) num = -num;
    if (span < 0) span = -span;
    w = (longint'(num) << FRACTION_BITS) / longint'(span);
    return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
  endfunction

  function automatic logic [VAL_W-1:0] mix(logic [VAL_W-1:0] l, logic [VAL_W-1:0] r,
                                           longint unsigned w);
    longint unsigned acc;
    acc = longint'(l) * (WEIGHT_ONE - w) + longint'(r) * w;
    return VAL_W'(acc >> FRACTION_BITS);
  endfunction

  function automatic logic [BYTE_W-1:0] to_palette(logic [VAL_W-1:0] v);
    return BYTE_W'((int'(v) * 255) / 65535);
  endfunction

  // Result the block owes for one request; write requests also update the
  // shadow tables here.
  function automatic tf_result_t transfer_outcome(tf_request_t req);
    tf_result_t res;
    int unsigned ci, oi;
    longint unsigned cw, ow;
    res = '0;
    case (req.cmd)
      CMD_WRITE_COLOR: begin
        color_pos[req.idx]   = req.pos;
        color_red[req.idx]   = req.red;
        color_green[req.idx] = req.green;
        color_blue[req.idx]  = req.blue;
        res.status = STATUS_WRITE;
      end
      CMD_WRITE_OPACITY: begin
        opacity_pos[req.idx] = req.pos;
        opacity_val[req.idx] = req.alpha;
        res.status = STATUS_WRITE;
      end
      CMD_SAMPLE: begin
        ci = right_index(1'b0, usable(color_count), req.pos);
        cw = pair_weight(color_pos[ci - 1], color_pos[ci], req.pos);
        oi = right_index(1'b1, usable(opacity_count), req.pos);
        ow = pair_weight(opacity_pos[oi - 1], opacity_pos[oi], req.pos);
        res.status    = STATUS_SAMPLE;
        res.red       = mix(color_red[ci - 1], color_red[ci], cw);
        res.green     = mix(color_green[ci - 1], color_green[ci], cw);
        res.blue      = mix(color_blue[ci - 1], color_blue[ci], cw);
        res.alpha     = mix(opacity_val[oi - 1], opacity_val[oi], ow);
        res.pal_red   = to_palette(res.red);
        res.pal_green = to_palette(res.green);
        res.pal_blue  = to_palette(res.blue);
      end
      default: res.status = STATUS_ERROR;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. Results cannot be held off, so every strobe is compared on
  // the edge that ends its cycle against the oldest outstanding expectation.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tf_result_t exp;
    if (!rst && done) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result with status %0d arrived with no request outstanding", status);
        mismatches++;
      end else begin
        exp = awaited_results.pop_front();
        check_field("status", exp.status, status);
        check_field("red_out", exp.red, red_out);
        check_field("green_out", exp.green, green_out);
        check_field("blue_out", exp.blue, blue_out);
        check_field("alpha_out", exp.alpha, alpha_out);
        check_field("palette_red", exp.pal_red, palette_red);
        check_field("palette_green", exp.pal_green, palette_green);
        check_field("palette_blue", exp.pal_blue, palette_blue);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Idle cycles before the next request: mostly none or a few, now and then a
  // long pause, and occasional bursts with no gaps at all.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Every field random, so bits the command ignores still toggle.
  function automatic tf_request_t random_fields();
    tf_request_t req;
    req.cmd   = CMD_W'($urandom_range(0, 3));
    req.idx   = INDEX_W'($urandom_range(0, MAX_POINTS - 1));
    req.pos   = POS_W'($urandom_range(0, 65535));
    req.red   = rand_value();
    req.green = rand_value();
    req.blue  = rand_value();
    req.alpha = rand_value();
    return req;
  endfunction

  // Presents one request and returns on the edge where it is taken. The
  // request stays on the port afterwards; the next call either replaces it in
  // the same step or lowers start, so start is never pulsed within one step.
  task automatic send(input tf_row_t row, input int unsigned gap);
    tf_result_t exp;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command     <= row.req.cmd;
    point_index <= row.req.idx;
    position    <= row.req.pos;
    red_in      <= row.req.red;
    green_in    <= row.req.green;
    blue_in     <= row.req.blue;
    alpha_in    <= row.req.alpha;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    exp = transfer_outcome(row.req);
    awaited_results.push_back(row.typed ? row.want : exp);
    case (row.req.cmd)
      CMD_SAMPLE:                         n_samples++;
      CMD_WRITE_COLOR, CMD_WRITE_OPACITY: n_writes++;
      default:                            n_bad++;
    endcase
  endtask

  task automatic send_random(input tf_request_t req);
    tf_row_t row;
    row = '{req: req, typed: 1'b0, want: '0};
    send(row, next_gap());
  endtask

  task automatic wait_idle();
    while (awaited_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Both count registers, one per edge. Only called with the block idle.
  task automatic set_counts(input logic [COUNT_W-1:0] c, input logic [COUNT_W-1:0] o);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLOR_COUNT;
    cfg_data  <= c;
    @(posedge clk);
    color_count = c;
    cfg_index <= REG_OPACITY_COUNT;
    cfg_data  <= o;
    @(posedge clk);
    opacity_count = o;
    cfg_we <= 1'b0;
  endtask

  // Fills the active part of one table with points in ascending order. Some
  // neighbors are pulled within a few LSB of each other so narrow spans occur.
  task automatic rebuild_table(input logic on_opacity, input int unsigned n);
    int unsigned p[$];
    tf_request_t req;
    p = {};
    for (int i = 0; i < n; i++) p.push_back($urandom_range(0, 65535));
    p.sort();
    for (int i = 1; i < n; i++)
      if ($urandom_range(0, 7) == 0) p[i] = (p[i - 1] + $urandom_range(0, 8)) & 16'hFFFF;
    p.sort();
    if ($urandom_range(0, 3) == 0) begin
      p[0] = 0;
      p[n - 1] = 65535;
    end
    for (int i = 0; i < n; i++) begin
      req = random_fields();
      req.cmd = on_opacity ? CMD_WRITE_OPACITY : CMD_WRITE_COLOR;
      req.idx = INDEX_W'(i);
      req.pos = POS_W'(p[i]);
      send_random(req);
    end
  endtask

  // A mix of samples (many close to stored points or at the range ends),
  // writes that keep the table in order, and noise: writes anywhere and the
  // invalid command.
  task automatic random_phase();
    tf_request_t req;
    logic on_opacity;
    int unsigned pick, n, i, lo, hi;
    int near_pos;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      req = random_fields();
      pick = $urandom_range(0, 99);
      on_opacity = 1'($urandom_range(0, 1));
      n = on_opacity ? usable(opacity_count) : usable(color_count);
      if (pick < 62) begin
        req.cmd = CMD_SAMPLE;
        case ($urandom_range(0, 9))
          0: req.pos = '0;
          1: req.pos = '1;
          2, 3, 4: begin
            near_pos = int'({16'd0, pos_at(on_opacity, $urandom_range(0, n - 1))})
                       + int'($urandom_range(0, 16)) - 8;
            if (near_pos < 0) near_pos = 0;
            if (near_pos > 65535) near_pos = 65535;
            req.pos = POS_W'(near_pos);
          end
          default: ;
        endcase
      end else if (pick < 76) begin
        req.cmd = on_opacity ? CMD_WRITE_OPACITY : CMD_WRITE_COLOR;
        i = $urandom_range(0, n - 1);
        lo = (i > 0) ? pos_at(on_opacity, i - 1) : 0;
        hi = (i < n - 1) ? pos_at(on_opacity, i + 1) : 65535;
        req.idx = INDEX_W'(i);
        if (lo <= hi) req.pos = POS_W'($urandom_range(hi, lo));
      end else if (pick < 94) begin
        req.cmd = on_opacity ? CMD_WRITE_OPACITY : CMD_WRITE_COLOR;
      end else begin
        req.cmd = CMD_UNUSED;
      end
      send_random(req);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed requests, run on the power-on tables and counts. The typed rows
  // are those whose result is obvious: the two range ends on the default maps,
  // write acknowledges and the invalid command. The rest go to the model.
  // --------------------------------------------------------------------------
  tf_row_t directed_rows [N_DIRECTED];

  task automatic load_directed_rows();
    // Query at zero: first pair, zero weight, so the pure left colors.
    directed_rows[0] = '{req: '{CMD_SAMPLE, 6'd0, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0},
                         typed: 1'b1,
                         want: '{STATUS_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                                 8'd0, 8'd0, 8'd255}};
    // Query at full scale: the clamp to the last pair avoids reading past it.
    directed_rows[1] = '{req: '{CMD_SAMPLE, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF},
                         typed: 1'b1,
                         want: '{STATUS_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                                 8'd255, 8'd0, 8'd0}};
    directed_rows[2] = '{req: '{CMD_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF}, typed: 1'b1, want: ERROR_ACK};
    directed_rows[3] = '{req: '{CMD_UNUSED, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
                         typed: 1'b1, want: ERROR_ACK};
    // Exactly on a stored point and on either side of mid-scale.
    directed_rows[4] = '{req: '{CMD_SAMPLE, 6'd0, 16'd19661, 16'h0, 16'h0, 16'h0, 16'h0},
                         typed: 1'b0, want: '0};
    directed_rows[5] = '{req: '{CMD_SAMPLE, 6'd0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0},
                         typed: 1'b0, want: '0};
    directed_rows[6] = '{req: '{CMD_SAMPLE, 6'd0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0},
                         typed: 1'b0, want: '0};
    // Writes to the last index, well past the active count: stored, no effect.
    directed_rows[7] = '{req: '{CMD_WRITE_COLOR, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'h0}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[8] = '{req: '{CMD_WRITE_OPACITY, 6'd63, 16'h0, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF}, typed: 1'b1, want: WRITE_ACK};
    // Move the first color point up, then query below it: the weight must not
    // go negative.
    directed_rows[9] = '{req: '{CMD_WRITE_COLOR, 6'd0, 16'd1000, 16'hFFFF, 16'h0, 16'h0,
                                16'h0}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[10] = '{req: '{CMD_SAMPLE, 6'd0, 16'd500, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    // A span of four LSB counts as narrow and gives the left color.
    directed_rows[11] = '{req: '{CMD_WRITE_COLOR, 6'd1, 16'd1004, 16'h0, 16'hFFFF, 16'h8000,
                                 16'h0}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[12] = '{req: '{CMD_SAMPLE, 6'd0, 16'd1002, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    // Seven LSB is just wide enough to interpolate.
    directed_rows[13] = '{req: '{CMD_WRITE_COLOR, 6'd2, 16'd1011, 16'h1234, 16'h0, 16'hFFFF,
                                 16'h0}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[14] = '{req: '{CMD_SAMPLE, 6'd0, 16'd1008, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    // Break the order of the opacity table; the probe order stays fixed.
    directed_rows[15] = '{req: '{CMD_WRITE_OPACITY, 6'd2, 16'd100, 16'h0, 16'h0, 16'h0,
                                 16'hFFFF}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[16] = '{req: '{CMD_SAMPLE, 6'd0, 16'd20000, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    directed_rows[17] = '{req: '{CMD_SAMPLE, 6'd0, 16'd40000, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    directed_rows[18] = '{req: '{CMD_WRITE_OPACITY, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0,
                                 16'hFFFF}, typed: 1'b1, want: WRITE_ACK};
    directed_rows[19] = '{req: '{CMD_SAMPLE, 6'd0, 16'hC000, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
    directed_rows[20] = '{req: '{CMD_SAMPLE, 6'd0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0},
                          typed: 1'b0, want: '0};
  endtask

  // Count settings per phase: minimum, table size, both below the minimum,
  // both above the table size, and some uneven mixes.
  logic [COUNT_W-1:0] color_setting   [N_SETTINGS] = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd9,
                                                       7'd5, 7'd33};
  logic [COUNT_W-1:0] opacity_setting [N_SETTINGS] = '{7'd2, 7'd64, 7'd1, 7'd65, 7'd13,
                                                       7'd40, 7'd3};

  initial begin
    mismatches   = 0;
    results_seen = 0;
    n_samples    = 0;
    n_writes     = 0;
    n_bad        = 0;
    burst_left   = 0;
    load_default_tables();
    load_directed_rows();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The block clears its tables after reset with busy high; send() simply
    // waits for that to finish before the first request goes in.
    for (int k = 0; k < N_DIRECTED; k++) send(directed_rows[k], next_gap());
    start <= 1'b0;

    for (int s = 0; s < N_SETTINGS; s++) begin
      wait_idle();
      set_counts(color_setting[s], opacity_setting[s]);
      rebuild_table(1'b0, usable(color_count));
      rebuild_table(1'b1, usable(opacity_count));
      random_phase();
      start <= 1'b0;
    end

    // Drain, then leave room for any stray strobe beyond the longest sample.
    wait_idle();
    repeat (100) @(posedge clk);

    $display("Sent %0d samples, %0d point writes and %0d invalid commands over %0d count settings.",
             n_samples, n_writes, n_bad, N_SETTINGS + 1);
    $display("Checked %0d results, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
